// ===== hdl/bfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the best-fit allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;
  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned AddrWidth = 30;
  localparam int unsigned IdxWidth  = $clog2(MaxBlocks);
  localparam int unsigned SizeWidth = AddrWidth + 1;
  localparam int unsigned EntWidth  = 1 + AddrWidth + SizeWidth;

  typedef enum logic [0:0] {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [0:0]  kind;
    logic [30:0] request_size;
    logic [29:0] release_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] value;
  } rsp_t;

  typedef struct packed {
    logic                 valid;
    logic [AddrWidth-1:0] start;
    logic [SizeWidth-1:0] size;
  } blk_t;

  typedef struct packed {
    logic                we;
    logic [IdxWidth-1:0] waddr;
    blk_t                wdata;
    logic [IdxWidth-1:0] raddr;
  } mem_ctl_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ASCAN,
    S_AFIND,
    S_AWR,
    S_RSCAN,
    S_FSCAN,
    S_RWR1,
    S_RWR2,
    S_OUT
  } state_e;
endpackage

// ===== hdl/best_fit_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_allocator
// Best-fit allocator with coalescing over a linear address space.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_stall_o carries kind, request_size and
// release_address; output channel out_valid_o/out_stall_i returns status and
// value, one result per request. A transfer is valid high with stall low.
// Allocation and free tables live in two 1024-entry synchronous RAMs.
// An allocate makes one pass over both tables. A release makes two passes
// (allocation lookup, then neighbor search in the free table). The pass
// length is set by the single read port of each RAM. One request is handled
// at a time.
// After reset and after every write of cfg_we_i a clearing pass over all 1024
// entries runs; no request is taken meanwhile.
// A finished result sits in the output register; a new request may be taken
// while it waits, and the next result waits until it has been transferred.
// ----------------------------------------------------------------------------
module best_fit_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [30:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bfa_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bfa_pkg::rsp_t  out_data_o
);
  import bfa_pkg::*;
  mem_ctl_t at_ctl, ft_ctl;
  blk_t at_rd, ft_rd;

  bfa_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .in_data_i, .out_valid_o, .out_stall_i, .out_data_o,
    .at_o(at_ctl), .at_rd_i(at_rd), .ft_o(ft_ctl), .ft_rd_i(ft_rd)
  );
  bfa_ram u_at (.clk_i, .ctl_i(at_ctl), .rdata_o(at_rd));
  bfa_ram u_ft (.clk_i, .ctl_i(ft_ctl), .rdata_o(ft_rd));
endmodule

// ===== hdl/bfa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ram
// Single-port-write, single-read table memory with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram (
  input  logic            clk_i,
  input  bfa_pkg::mem_ctl_t ctl_i,
  output bfa_pkg::blk_t   rdata_o
);
  import bfa_pkg::*;
  blk_t mem [MaxBlocks];
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) mem[ctl_i.waddr] <= ctl_i.wdata;
    rdata_o <= mem[ctl_i.raddr];
  end
endmodule

// ===== hdl/bfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: clears tables, scans them and writes back the updates.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [30:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bfa_pkg::req_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bfa_pkg::rsp_t     out_data_o,
  output bfa_pkg::mem_ctl_t at_o,
  input  bfa_pkg::blk_t     at_rd_i,
  output bfa_pkg::mem_ctl_t ft_o,
  input  bfa_pkg::blk_t     ft_rd_i
);
  import bfa_pkg::*;
  localparam logic [SizeWidth-1:0] Lim = SizeWidth'(1) << AddrWidth;

  state_e state_q, state_d;
  logic [SizeWidth-1:0] msize_q, msize_d;
  logic [IdxWidth:0]    cnt_q, cnt_d;
  logic                 rdv_q, rdv_d;
  logic [IdxWidth-1:0]  ridx_q, ridx_d;
  req_t                 req_q, req_d;
  rsp_t                 rsp_q, rsp_d;
  rsp_t                 out_q, out_d;
  logic                 ov_q, ov_d;
  logic                 bf_q, bf_d, af_q, af_d, fr_q, fr_d, bk_q, bk_d, ef_q, ef_d;
  logic [IdxWidth-1:0]  bi_q, bi_d, ai_q, ai_d, fi_q, fi_d, ki_q, ki_d, ei_q, ei_d;
  blk_t                 bb_q, bb_d, fb_q, fb_d, kb_q, kb_d;
  logic [SizeWidth-1:0] asz_q, asz_d;

  logic [30:0] wv;
  logic [SizeWidth-1:0] fend;
  logic [SizeWidth:0] rend;

  always_comb wv = (cfg_wdata_i > Lim) ? Lim : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; msize_q <= Lim; cnt_q <= '0; rdv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; msize_q <= msize_d; cnt_q <= cnt_d; rdv_q <= rdv_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= ridx_d; req_q <= req_d; rsp_q <= rsp_d; out_q <= out_d;
    bf_q <= bf_d; af_q <= af_d; fr_q <= fr_d; bk_q <= bk_d; ef_q <= ef_d;
    bi_q <= bi_d; ai_q <= ai_d; fi_q <= fi_d; ki_q <= ki_d; ei_q <= ei_d;
    bb_q <= bb_d; fb_q <= fb_d; kb_q <= kb_d; asz_q <= asz_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q; msize_d = msize_q; cnt_d = cnt_q; rdv_d = 1'b0;
    ridx_d = cnt_q[IdxWidth-1:0]; req_d = req_q; rsp_d = rsp_q; ov_d = ov_q;
    out_d = out_q;
    bf_d = bf_q; af_d = af_q; fr_d = fr_q; bk_d = bk_q; ef_d = ef_q;
    bi_d = bi_q; ai_d = ai_q; fi_d = fi_q; ki_d = ki_q; ei_d = ei_q;
    bb_d = bb_q; fb_d = fb_q; kb_d = kb_q; asz_d = asz_q;
    at_o = '0; ft_o = '0;
    at_o.raddr = cnt_q[IdxWidth-1:0]; ft_o.raddr = cnt_q[IdxWidth-1:0];
    fend = ft_rd_i.start + ft_rd_i.size;
    rend = {2'b0, req_q.release_address} + {1'b0, asz_q};
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        at_o.we = 1'b1; at_o.waddr = cnt_q[IdxWidth-1:0];
        ft_o.we = 1'b1; ft_o.waddr = cnt_q[IdxWidth-1:0];
        if (cnt_q == '0 && msize_q != '0) begin
          ft_o.wdata.valid = 1'b1; ft_o.wdata.size = msize_q;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (IdxWidth+1)'(MaxBlocks - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          req_d = in_data_i;
          bf_d = 1'b0; af_d = 1'b0; fr_d = 1'b0; bk_d = 1'b0; ef_d = 1'b0;
          if (in_data_i.kind == KIND_ALLOC) begin
            if (in_data_i.request_size == '0) begin
              rsp_d = '{ST_FAIL, '0}; state_d = S_OUT;
            end else state_d = S_ASCAN;
          end else state_d = S_RSCAN;
        end
      end
      S_ASCAN, S_RSCAN, S_FSCAN: begin
        if (cnt_q != (IdxWidth+1)'(MaxBlocks)) begin
          cnt_d = cnt_q + 1'b1; rdv_d = 1'b1;
        end
        if (rdv_q) begin
          if (state_q == S_ASCAN) begin
            if (ft_rd_i.valid && ft_rd_i.size >= req_q.request_size &&
                (!bf_q || ft_rd_i.size < bb_q.size ||
                 (ft_rd_i.size == bb_q.size && ft_rd_i.start < bb_q.start))) begin
              bf_d = 1'b1; bi_d = ridx_q; bb_d = ft_rd_i;
            end
            if (!at_rd_i.valid && !af_q) begin af_d = 1'b1; ai_d = ridx_q; end
          end else if (state_q == S_RSCAN) begin
            if (at_rd_i.valid && at_rd_i.start == req_q.release_address && !af_q) begin
              af_d = 1'b1; ai_d = ridx_q; asz_d = at_rd_i.size;
            end
          end else begin
            if (ft_rd_i.valid) begin
              if (fend == {1'b0, req_q.release_address}) begin
                fr_d = 1'b1; fi_d = ridx_q; fb_d = ft_rd_i;
              end
              if ({2'b0, ft_rd_i.start} == rend) begin
                bk_d = 1'b1; ki_d = ridx_q; kb_d = ft_rd_i;
              end
            end else if (!ef_q) begin ef_d = 1'b1; ei_d = ridx_q; end
          end
        end
        if (!rdv_q && cnt_q == (IdxWidth+1)'(MaxBlocks)) begin
          cnt_d = '0;
          if (state_q == S_ASCAN) state_d = S_AFIND;
          else if (state_q == S_RSCAN) begin
            if (!af_q) begin rsp_d = '{ST_FAIL, '0}; state_d = S_OUT; end
            else state_d = S_FSCAN;
          end else begin
            if (!fr_q && !bk_q && !ef_q) begin rsp_d = '{ST_FULL, '0}; state_d = S_OUT; end
            else state_d = S_RWR1;
          end
        end
      end
      S_AFIND: begin
        if (!bf_q) begin rsp_d = '{ST_FAIL, '0}; state_d = S_OUT; end
        else if (!af_q) begin rsp_d = '{ST_FULL, '0}; state_d = S_OUT; end
        else state_d = S_AWR;
      end
      S_AWR: begin
        at_o.we = 1'b1; at_o.waddr = ai_q;
        at_o.wdata = '{1'b1, bb_q.start, req_q.request_size};
        ft_o.we = 1'b1; ft_o.waddr = bi_q;
        if (bb_q.size > req_q.request_size)
          ft_o.wdata = '{1'b1, AddrWidth'(bb_q.start + req_q.request_size),
                         bb_q.size - req_q.request_size};
        rsp_d = '{ST_OK, SizeWidth'(bb_q.start)}; state_d = S_OUT;
      end
      S_RWR1: begin
        at_o.we = 1'b1; at_o.waddr = ai_q;
        ft_o.we = 1'b1;
        if (fr_q) begin
          ft_o.waddr = fi_q;
          ft_o.wdata = '{1'b1, fb_q.start, fb_q.size + asz_q + (bk_q ? kb_q.size : '0)};
        end else if (bk_q) begin
          ft_o.waddr = ki_q;
          ft_o.wdata = '{1'b1, req_q.release_address, kb_q.size + asz_q};
        end else begin
          ft_o.waddr = ei_q;
          ft_o.wdata = '{1'b1, req_q.release_address, asz_q};
        end
        rsp_d = '{ST_OK, asz_q};
        state_d = (fr_q && bk_q) ? S_RWR2 : S_OUT;
      end
      S_RWR2: begin
        ft_o.we = 1'b1; ft_o.waddr = ki_q; state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q) begin ov_d = 1'b1; out_d = rsp_q; state_d = S_IDLE; end
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) begin
      msize_d = wv; cnt_d = '0; state_d = S_CLEAR;
    end
  end
endmodule

// ===== hdl/bfa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the best-fit allocator.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bfa_pkg::rsp_t out_data_o
);
  import bfa_pkg::*;
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_FULL)
    else $error("bad status");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.value == '0)
    else $error("value on failure");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("took two requests back to back");
endmodule

bind best_fit_allocator bfa_checker u_chk (.*);
